// ===== src/time_of_day_clock_with_key_setter_macros.svh =====
// ----------------------------------------------------------------------------
// time-of-day clock assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_WITH_KEY_SETTER_MACROS_SVH
`define TIME_OF_DAY_CLOCK_WITH_KEY_SETTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define TDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TDC_ASSERT(lbl, prop, msg)
`define TDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// time-of-day clock package
// Item types, state record, codes and wrap helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

    // event codes
    localparam logic [1:0] FUNC_SECOND = 2'd0;
    localparam logic [1:0] FUNC_KEY    = 2'd1;
    localparam logic [1:0] FUNC_HOLD   = 2'd2;
    localparam logic [1:0] FUNC_BLINK  = 2'd3;

    // page codes
    localparam logic [1:0] PAGE_MAIN  = 2'd0;
    localparam logic [1:0] PAGE_CLOCK = 2'd1;
    localparam logic [1:0] PAGE_ALARM = 2'd2;

    // field codes
    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;

    // key codes
    localparam logic [2:0] KEY_1 = 3'd1;
    localparam logic [2:0] KEY_2 = 3'd2;
    localparam logic [2:0] KEY_3 = 3'd3;
    localparam logic [2:0] KEY_4 = 3'd4;

    localparam logic [5:0]  HOUR_LAST   = 6'd23;
    localparam logic [5:0]  MINSEC_LAST = 6'd59;
    localparam logic [5:0]  FIELD_LAST  = 6'd2;
    localparam logic [15:0] HOLD_MAX    = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET = 16'd10000;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic [5:0] alarm_seconds;
        logic [1:0] page;
        logic [1:0] field_select;
        logic [2:0] led_pattern;
        logic [1:0] change_flags;
        logic [7:0] clock_edit_count;
        logic [7:0] alarm_edit_count;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  clock_hours;
        logic [5:0]  clock_minutes;
        logic [5:0]  clock_seconds;
        logic [4:0]  set_alarm_hours;
        logic [5:0]  set_alarm_minutes;
        logic [5:0]  set_alarm_seconds;
        logic [1:0]  current_page;
        logic [1:0]  clock_field;
        logic [1:0]  alarm_field;
        logic [2:0]  previous_key;
        logic [15:0] hold_count;
        logic [1:0]  pending_flags;
        logic [7:0]  clock_edits;
        logic [7:0]  alarm_edits;
        logic        blink_phase;
    } t_state;

    localparam t_state STATE_RESET = '{
        clock_hours:       5'd11,
        clock_minutes:     6'd59,
        clock_seconds:     6'd50,
        set_alarm_hours:   5'd12,
        set_alarm_minutes: 6'd0,
        set_alarm_seconds: 6'd0,
        current_page:      PAGE_MAIN,
        clock_field:       FIELD_HOURS,
        alarm_field:       FIELD_HOURS,
        previous_key:      3'd0,
        hold_count:        16'd0,
        pending_flags:     2'd0,
        clock_edits:       8'd0,
        alarm_edits:       8'd0,
        blink_phase:       1'b0
    };

    function automatic logic [5:0] f_step_up(logic [5:0] v, logic [5:0] last);
        return (v >= last) ? 6'd0 : v + 6'd1;
    endfunction

    function automatic logic [5:0] f_step_down(logic [5:0] v, logic [5:0] last);
        return (v == 6'd0) ? last : v - 6'd1;
    endfunction

endpackage

`default_nettype wire

// ===== src/tdc_engine.sv =====
// ----------------------------------------------------------------------------
// time-of-day clock engine
// Clock, alarm and key state with its single-pass update per item.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_engine
    import tdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_in_item    i_item,
    input  wire logic [15:0] i_long_press_limit,
    output t_out_item        o_result
);

    t_state r_state;
    t_state n_state;

    // raise or lower the selected field of the shown setting page
    function automatic t_state f_adjust(t_state s, logic raise);
        t_state     t;
        logic [1:0] fld;
        logic [5:0] h;
        logic [5:0] m;
        logic [5:0] sec;
        t   = s;
        fld = FIELD_HOURS;
        h   = 6'd0;
        m   = 6'd0;
        sec = 6'd0;
        if (s.current_page == PAGE_CLOCK) begin
            h   = {1'b0, s.clock_hours};
            m   = s.clock_minutes;
            sec = s.clock_seconds;
            fld = s.clock_field;
        end else if (s.current_page == PAGE_ALARM) begin
            h   = {1'b0, s.set_alarm_hours};
            m   = s.set_alarm_minutes;
            sec = s.set_alarm_seconds;
            fld = s.alarm_field;
        end
        case (fld)
            FIELD_HOURS:   h   = raise ? f_step_up(h, HOUR_LAST)
                                       : f_step_down(h, HOUR_LAST);
            FIELD_MINUTES: m   = raise ? f_step_up(m, MINSEC_LAST)
                                       : f_step_down(m, MINSEC_LAST);
            FIELD_SECONDS: sec = raise ? f_step_up(sec, MINSEC_LAST)
                                       : f_step_down(sec, MINSEC_LAST);
            default: ;
        endcase
        if (s.current_page == PAGE_CLOCK) begin
            t.clock_hours      = h[4:0];
            t.clock_minutes    = m;
            t.clock_seconds    = sec;
            t.pending_flags[0] = 1'b1;
        end else if (s.current_page == PAGE_ALARM) begin
            t.set_alarm_hours   = h[4:0];
            t.set_alarm_minutes = m;
            t.set_alarm_seconds = sec;
            t.pending_flags[1]  = 1'b1;
        end
        return t;
    endfunction

    always_comb begin
        logic [2:0] diff;
        logic [2:0] press;
        logic [2:0] release_code;
        logic [5:0] tmp;
        n_state      = r_state;
        diff         = i_item.key_code ^ r_state.previous_key;
        press        = i_item.key_code & diff;
        release_code = ~i_item.key_code & diff;
        tmp          = 6'd0;
        unique case (i_item.func)
            FUNC_SECOND: begin
                // clock stands still while it is being set
                if (n_state.current_page != PAGE_CLOCK) begin
                    if (n_state.clock_seconds >= MINSEC_LAST) begin
                        n_state.clock_seconds = 6'd0;
                        if (n_state.clock_minutes >= MINSEC_LAST) begin
                            n_state.clock_minutes = 6'd0;
                            tmp = f_step_up({1'b0, n_state.clock_hours}, HOUR_LAST);
                            n_state.clock_hours = tmp[4:0];
                        end else begin
                            n_state.clock_minutes = n_state.clock_minutes + 6'd1;
                        end
                    end else begin
                        n_state.clock_seconds = n_state.clock_seconds + 6'd1;
                    end
                end
            end
            FUNC_KEY: begin
                n_state.previous_key = i_item.key_code;
                if (press == KEY_1) begin
                    if (n_state.current_page != PAGE_ALARM) begin
                        n_state.current_page = (n_state.current_page == PAGE_MAIN)
                                             ? PAGE_CLOCK : PAGE_MAIN;
                        if (n_state.pending_flags[0]) begin
                            n_state.clock_edits      = n_state.clock_edits + 8'd1;
                            n_state.pending_flags[0] = 1'b0;
                        end
                    end else begin
                        tmp = f_step_up({4'd0, n_state.alarm_field}, FIELD_LAST);
                        n_state.alarm_field = tmp[1:0];
                    end
                end
                if (press == KEY_2) begin
                    if (n_state.current_page != PAGE_CLOCK) begin
                        n_state.current_page = (n_state.current_page == PAGE_MAIN)
                                             ? PAGE_ALARM : PAGE_MAIN;
                        if (n_state.pending_flags[1]) begin
                            n_state.alarm_edits      = n_state.alarm_edits + 8'd1;
                            n_state.pending_flags[1] = 1'b0;
                        end
                    end else begin
                        tmp = f_step_up({4'd0, n_state.clock_field}, FIELD_LAST);
                        n_state.clock_field = tmp[1:0];
                    end
                end
                if (press == KEY_3 || press == KEY_4) begin
                    n_state.hold_count = 16'd0;
                end
                // short press acts on release, long hold repeats per sample
                if (n_state.hold_count < i_long_press_limit) begin
                    if (release_code == KEY_3) n_state = f_adjust(n_state, 1'b1);
                    if (release_code == KEY_4) n_state = f_adjust(n_state, 1'b0);
                end else begin
                    if (i_item.key_code == KEY_3) n_state = f_adjust(n_state, 1'b1);
                    if (i_item.key_code == KEY_4) n_state = f_adjust(n_state, 1'b0);
                end
            end
            FUNC_HOLD: begin
                if (n_state.hold_count != HOLD_MAX) begin
                    n_state.hold_count = n_state.hold_count + 16'd1;
                end
            end
            FUNC_BLINK: begin
                if (n_state.current_page == PAGE_MAIN) begin
                    n_state.blink_phase = ~n_state.blink_phase;
                end
            end
            default: ;
        endcase
        if (n_state.current_page != PAGE_MAIN) begin
            n_state.blink_phase = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_result.hours            = n_state.clock_hours;
        o_result.minutes          = n_state.clock_minutes;
        o_result.seconds          = n_state.clock_seconds;
        o_result.alarm_hours      = n_state.set_alarm_hours;
        o_result.alarm_minutes    = n_state.set_alarm_minutes;
        o_result.alarm_seconds    = n_state.set_alarm_seconds;
        o_result.page             = n_state.current_page;
        o_result.change_flags     = n_state.pending_flags;
        o_result.clock_edit_count = n_state.clock_edits;
        o_result.alarm_edit_count = n_state.alarm_edits;
        o_result.led_pattern      = {n_state.current_page == PAGE_ALARM,
                                     n_state.current_page == PAGE_CLOCK,
                                     n_state.blink_phase};
        if (n_state.current_page == PAGE_CLOCK) begin
            o_result.field_select = n_state.clock_field;
        end else if (n_state.current_page == PAGE_ALARM) begin
            o_result.field_select = n_state.alarm_field;
        end else begin
            o_result.field_select = FIELD_HOURS;
        end
    end

endmodule

`default_nettype wire

// ===== src/time_of_day_clock_with_key_setter.sv =====
// ----------------------------------------------------------------------------
// time-of-day clock with key setter
// Clock and alarm kept from second ticks, key samples, hold and blink ticks.
// ----------------------------------------------------------------------------
// Each item (second tick, key sample, hold tick or blink tick) is captured in
// an input register, passes through the combinational state update, and the
// resulting clock, alarm, page, LED and edit-count snapshot lands in an output
// register. One item is taken every cycle while results are drained, the state
// update being a single combinational pass. Stall on the output propagates to
// the input only when both registers are full. After reset the clock reads
// 11:59:50 and the alarm 12:00:00; keys 3 and 4 auto-repeat once the hold
// counter reaches the long-press limit (reset 10000), which may be rewritten
// while idle.
`default_nettype none

`include "time_of_day_clock_with_key_setter_macros.svh"

module time_of_day_clock_with_key_setter
    import tdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_item    i_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_item        o_item,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_limit;
    logic        advance;
    logic        accept;
    t_out_item   result;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    tdc_engine u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (advance),
        .i_item             (r_in_item),
        .i_long_press_limit (r_limit),
        .o_result           (result)
    );

    `TDC_ASSERT(a_stall_needs_full_input, o_stall |-> r_in_valid && r_out_valid, "stall with free slot")
    `TDC_ASSERT(a_step_gives_result, advance |=> o_valid, "processed item gave no result")
    `TDC_ASSERT(a_blink_main_only, o_valid && o_item.page != PAGE_MAIN |-> !o_item.led_pattern[0], "blink off main page")
    `TDC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_valid && !r_in_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire
